[hdl/battery_guard_supervisor_unit_macros.svh]
// Assertion helpers for the battery guard supervisor.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef BATTERY_GUARD_SUPERVISOR_UNIT_MACROS_SVH
`define BATTERY_GUARD_SUPERVISOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define BGS_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

`define BGS_ASSERT(label, prop, msg) \
    `BGS_ASSERT_CLK(label, clk, rst_n, prop, msg)

`else

`define BGS_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)

`define BGS_ASSERT(label, prop, msg)

`endif

`endif

[hdl/bgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bgs_pkg;

    // Operation codes of an input word
    localparam logic OP_WAKE  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_DAYS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKES_PER_DAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DUE_W      = 26;   // restart_days x wakes_per_day

    // Reset values of the configuration registers
    localparam logic [15:0] OFF_THRESHOLD_RST  = 16'd3330;
    localparam logic [15:0] ON_THRESHOLD_RST   = 16'd3700;
    localparam logic [15:0] FULL_SCALE_RST     = 16'd5070;
    localparam logic [9:0]  RESTART_DAYS_RST   = 10'd7;
    localparam logic [15:0] WAKES_PER_DAY_RST  = 16'd37565;
    localparam logic [3:0]  CHECK_INTERVAL_RST = 4'd13;
    localparam logic [DUE_W-1:0] DUE_RST       = 26'd262955;

    // State reset values
    localparam logic [3:0] WAKE_COUNTER_RST = 4'd15;

    // LED feedback codes
    localparam logic [2:0] BLINKS_NONE = 3'd0;
    localparam logic [2:0] BLINKS_MID  = 3'd3;
    localparam logic [2:0] BLINKS_LOW  = 3'd6;

    typedef enum logic [1:0] {
        PULSE_NONE      = 2'd0,
        PULSE_SCHEDULED = 2'd1,
        PULSE_BUTTON    = 2'd2
    } pulse_t;

    // Configuration seen by the decision logic
    typedef struct packed {
        logic [15:0]      off_threshold_mv;
        logic [15:0]      on_threshold_mv;
        logic [9:0]       restart_days;
        logic [15:0]      wakes_per_day;
        logic [3:0]       check_interval;
        logic [DUE_W-1:0] due_wakes;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic        load_on;
        pulse_t      restart_pulse;
        logic        measured;
        logic [15:0] battery_mv;
        logic [2:0]  led_blinks;
        logic        save_request;
        logic        in_maintenance;
    } result_t;

endpackage

`default_nettype wire

[hdl/battery_guard_supervisor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Battery guard supervisor. Each input word is one pass of the supervisor:
// a watchdog wake tick or a finished button press, carrying one ADC sample.
// Every word gives exactly one result word. A word is captured in an input
// register, converted and decided combinationally (one ADC_BITS x 16
// multiply for the millivolt value plus threshold compares and counter
// updates), and stored in the result register, which drives the result
// port; one word is taken per cycle while the result side keeps up.
// While a finished result waits, the input register can still take one
// word; with both registers full, item_stall follows result_stall. The
// scheduled-restart threshold (restart_days x wakes_per_day) is multiplied
// and stored when any configuration register is written.
// Configuration writes are always accepted (cfg_ready is high) and must only
// happen while no word is in flight.
module battery_guard_supervisor_unit #(
    parameter int unsigned ADC_BITS        = 10,
    parameter int unsigned SHORT_PRESS_MIN = 10,
    parameter int unsigned LONG_PRESS      = 50
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    // input words
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic                         op,
    input  wire logic [ADC_BITS-1:0]          adc_code,
    input  wire logic [5:0]                   hold_tenths,

    // result words
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic                              load_on,
    output logic [1:0]                        restart_pulse,
    output logic                              measured,
    output logic [15:0]                       battery_mv,
    output logic [2:0]                        led_blinks,
    output logic                              save_request,
    output logic                              in_maintenance,

    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [15:0]               off_threshold_reg;
    logic [15:0]               on_threshold_reg;
    logic [15:0]               full_scale_reg;
    logic [9:0]                restart_days_reg;
    logic [15:0]               wakes_per_day_reg;
    logic [3:0]                check_interval_reg;
    logic [bgs_pkg::DUE_W-1:0] due_reg, due_next;
    logic [9:0]                restart_days_new;
    logic [15:0]               wakes_per_day_new;
    logic                      cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // new threshold product uses the value being written, so it is
    // ready on the same edge as the register itself
    assign restart_days_new = (cfg_write && cfg_index == bgs_pkg::CFG_RESTART_DAYS)
                              ? cfg_data[9:0] : restart_days_reg;
    assign wakes_per_day_new = (cfg_write && cfg_index == bgs_pkg::CFG_WAKES_PER_DAY)
                               ? cfg_data : wakes_per_day_reg;
    assign due_next = {16'd0, restart_days_new} * {10'd0, wakes_per_day_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_threshold_reg  <= bgs_pkg::OFF_THRESHOLD_RST;
            on_threshold_reg   <= bgs_pkg::ON_THRESHOLD_RST;
            full_scale_reg     <= bgs_pkg::FULL_SCALE_RST;
            restart_days_reg   <= bgs_pkg::RESTART_DAYS_RST;
            wakes_per_day_reg  <= bgs_pkg::WAKES_PER_DAY_RST;
            check_interval_reg <= bgs_pkg::CHECK_INTERVAL_RST;
            due_reg            <= bgs_pkg::DUE_RST;
        end
        else if (cfg_write)
        begin
            due_reg <= due_next;
            unique case (cfg_index)
                bgs_pkg::CFG_OFF_THRESHOLD:  off_threshold_reg  <= cfg_data;
                bgs_pkg::CFG_ON_THRESHOLD:   on_threshold_reg   <= cfg_data;
                bgs_pkg::CFG_FULL_SCALE:     full_scale_reg     <= cfg_data;
                bgs_pkg::CFG_RESTART_DAYS:   restart_days_reg   <= cfg_data[9:0];
                bgs_pkg::CFG_WAKES_PER_DAY:  wakes_per_day_reg  <= cfg_data;
                bgs_pkg::CFG_CHECK_INTERVAL: check_interval_reg <= cfg_data[3:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    bgs_pkg::cfg_t cfg;

    always_comb
    begin
        cfg.off_threshold_mv = off_threshold_reg;
        cfg.on_threshold_mv  = on_threshold_reg;
        cfg.restart_days     = restart_days_reg;
        cfg.wakes_per_day    = wakes_per_day_reg;
        cfg.check_interval   = check_interval_reg;
        cfg.due_wakes        = due_reg;
    end

    // ---------------- input register ----------------
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_op_reg;
    logic [ADC_BITS-1:0] s1_adc_reg;
    logic [5:0]          s1_hold_reg;
    logic                result_valid_reg, result_valid_next;
    logic                out_free;
    logic                advance;
    logic                item_take;

    // result slot frees when empty or when its word leaves this edge
    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign item_take  = item_valid && !item_stall;

    assign s1_valid_next = item_take || (s1_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_op_reg   <= op;
            s1_adc_reg  <= adc_code;
            s1_hold_reg <= hold_tenths;
        end
    end

    // ---------------- conversion and decision ----------------
    logic [15:0]      mv;
    bgs_pkg::result_t result;

    bgs_mv #(
        .ADC_BITS (ADC_BITS)
    ) u_mv (
        .adc_code      (s1_adc_reg),
        .full_scale_mv (full_scale_reg),
        .battery_mv    (mv)
    );

    // supervisor state commits only when the word moves to the result slot
    bgs_core #(
        .SHORT_PRESS_MIN (SHORT_PRESS_MIN),
        .LONG_PRESS      (LONG_PRESS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .op          (s1_op_reg),
        .hold_tenths (s1_hold_reg),
        .battery_mv  (mv),
        .cfg         (cfg),
        .result      (result)
    );

    // ---------------- result register ----------------
    bgs_pkg::result_t result_reg;

    assign result_valid_next = out_free ? s1_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign result_valid   = result_valid_reg;
    assign load_on        = result_reg.load_on;
    assign restart_pulse  = result_reg.restart_pulse;
    assign measured       = result_reg.measured;
    assign battery_mv     = result_reg.battery_mv;
    assign led_blinks     = result_reg.led_blinks;
    assign save_request   = result_reg.save_request;
    assign in_maintenance = result_reg.in_maintenance;

    // ---------------- checks ----------------
`include "battery_guard_supervisor_unit_macros.svh"

    // maintenance mode always holds the load off
    `BGS_ASSERT(a_maint_load_off, result_valid && in_maintenance |-> !load_on, "load on in maintenance")
    // a scheduled off cycle is only requested with the load powered
    `BGS_ASSERT(a_sched_needs_load, result_valid && restart_pulse == bgs_pkg::PULSE_SCHEDULED |-> load_on, "scheduled pulse with load off")
    // a save request always carries a fresh measurement
    `BGS_ASSERT(a_save_measured, result_valid && save_request |-> measured, "save without measurement")
    // LED feedback only comes with a medium press
    `BGS_ASSERT(a_blinks_press, result_valid && led_blinks != bgs_pkg::BLINKS_NONE |-> save_request, "blinks without press")

endmodule

`default_nettype wire

[hdl/bgs_mv.sv]
`timescale 1ns / 1ps
`default_nettype none

// ADC code to millivolts: (code * full_scale) >> ADC_BITS.
// The shifted product is always below 2^16, so no saturation is needed.
module bgs_mv #(
    parameter int unsigned ADC_BITS = 10
) (
    input  wire logic [ADC_BITS-1:0] adc_code,
    input  wire logic [15:0]         full_scale_mv,
    output logic      [15:0]         battery_mv
);

    logic [ADC_BITS+15:0] product;

    assign product    = {16'd0, adc_code} * {{ADC_BITS{1'b0}}, full_scale_mv};
    assign battery_mv = product[ADC_BITS +: 16];

endmodule

`default_nettype wire

[hdl/bgs_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Supervisor state and the per-word decision logic.
module bgs_core #(
    parameter int unsigned SHORT_PRESS_MIN = 10,
    parameter int unsigned LONG_PRESS      = 50
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          op,
    input  wire logic [5:0]    hold_tenths,
    input  wire logic [15:0]   battery_mv,
    input  wire bgs_pkg::cfg_t cfg,
    output bgs_pkg::result_t   result
);

    localparam logic [7:0] LONG_HOLD  = 8'(LONG_PRESS);
    localparam logic [7:0] SHORT_HOLD = 8'(SHORT_PRESS_MIN);

    logic [3:0]  wake_counter_reg, wake_counter_next;
    logic [31:0] day_counter_reg, day_counter_next;
    logic        load_state_reg, load_state_next;
    logic        maintenance_reg, maintenance_next;
    logic        started_reg;

    logic [7:0]  hold_ext;
    logic        above_off;
    logic        below_on;
    logic        measured;
    logic        save;
    logic [2:0]  blinks;
    bgs_pkg::pulse_t pulse;

    assign hold_ext  = {2'b00, hold_tenths};
    assign above_off = battery_mv > cfg.off_threshold_mv;
    assign below_on  = battery_mv < cfg.on_threshold_mv;

    always_comb
    begin
        wake_counter_next = wake_counter_reg;
        day_counter_next  = day_counter_reg;
        load_state_next   = load_state_reg;
        maintenance_next  = maintenance_reg;
        measured          = 1'b0;
        save              = 1'b0;
        blinks            = bgs_pkg::BLINKS_NONE;
        pulse             = bgs_pkg::PULSE_NONE;

        // first word after reset: decide the load from this sample
        if (!started_reg)
        begin
            measured         = 1'b1;
            load_state_next  = above_off;
            maintenance_next = 1'b0;
        end

        if (op == bgs_pkg::OP_PRESS)
        begin
            if (maintenance_next)
            begin
                if (hold_ext >= LONG_HOLD)
                begin
                    maintenance_next  = 1'b0;
                    load_state_next   = 1'b1;
                    wake_counter_next = 4'd0;
                    day_counter_next  = 32'd0;
                end
            end
            else if (hold_ext >= LONG_HOLD)
            begin
                maintenance_next = 1'b1;
                load_state_next  = 1'b0;
            end
            else if (hold_ext >= SHORT_HOLD)
            begin
                measured = 1'b1;
                save     = 1'b1;
                priority if (above_off && below_on)
                    blinks = bgs_pkg::BLINKS_MID;
                else if (!above_off)
                    blinks = bgs_pkg::BLINKS_LOW;
                else
                    blinks = bgs_pkg::BLINKS_NONE;
                pulse             = bgs_pkg::PULSE_BUTTON;
                load_state_next   = above_off;
                wake_counter_next = 4'd0;
                day_counter_next  = 32'd0;
            end
        end

        if (!maintenance_next)
        begin
            if (wake_counter_next >= cfg.check_interval)
            begin
                measured = 1'b1;
                if (!above_off)
                    load_state_next = 1'b0;
                if (!below_on)
                    load_state_next = 1'b1;   // on test wins when thresholds cross
                if (cfg.restart_days != 10'd0)
                begin
                    if (day_counter_next >= {6'd0, cfg.due_wakes})
                    begin
                        if (load_state_next)
                            pulse = bgs_pkg::PULSE_SCHEDULED;
                        day_counter_next = 32'd0;
                    end
                end
                else if (day_counter_next > {16'd0, cfg.wakes_per_day})
                begin
                    day_counter_next = 32'd0;
                end
                wake_counter_next = 4'd0;
            end
            wake_counter_next = wake_counter_next + 4'd1;
            day_counter_next  = day_counter_next + 32'd1;
        end
    end

    always_comb
    begin
        result.load_on        = load_state_next;
        result.restart_pulse  = pulse;
        result.measured       = measured;
        result.battery_mv     = measured ? battery_mv : 16'd0;
        result.led_blinks     = blinks;
        result.save_request   = save;
        result.in_maintenance = maintenance_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_counter_reg <= bgs_pkg::WAKE_COUNTER_RST;
            day_counter_reg  <= 32'd0;
            load_state_reg   <= 1'b0;
            maintenance_reg  <= 1'b0;
            started_reg      <= 1'b0;
        end
        else if (advance)
        begin
            wake_counter_reg <= wake_counter_next;
            day_counter_reg  <= day_counter_next;
            load_state_reg   <= load_state_next;
            maintenance_reg  <= maintenance_next;
            started_reg      <= 1'b1;
        end
    end

endmodule

`default_nettype wire
